>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the dda rasterizer
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// shared types and constants of the dda line rasterizer
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COORD_BITS      = 11;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    // stream widths, rounded up to whole bytes
    localparam int S_TDATA_W = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] mag_t;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    // classified command passed from front to back
    typedef struct packed {
        op_t    op;
        coord_t start_x;
        coord_t start_y;
        mag_t   mag_x;
        mag_t   mag_y;
        logic   neg_x;
        logic   neg_y;
        mag_t   steps;
    } cmd_t;

endpackage

>>> design/dda_front.sv
// ----------------------------------------------------------------------------
// dda_front
// accepts input transfers and classifies them into line commands
// ----------------------------------------------------------------------------
module dda_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dda_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          q_ready,
    output logic                          q_push,
    output dda_pkg::cmd_t                 q_cmd
);
    import dda_pkg::*;

    coord_t                 sx, sy, ex, ey;
    logic signed [COORD_BITS:0] dx, dy;
    mag_t                   ax, ay;

    assign sx = s_tdata[0*COORD_BITS +: COORD_BITS];
    assign sy = s_tdata[1*COORD_BITS +: COORD_BITS];
    assign ex = s_tdata[2*COORD_BITS +: COORD_BITS];
    assign ey = s_tdata[3*COORD_BITS +: COORD_BITS];

    assign dx = {ex[COORD_BITS-1], ex} - {sx[COORD_BITS-1], sx};
    assign dy = {ey[COORD_BITS-1], ey} - {sy[COORD_BITS-1], sy};

    // magnitudes never exceed 2^COORD_BITS - 1
    assign ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];

    always_comb begin
        q_cmd.op      = s_tuser ? OP_ADVANCE : OP_START;
        q_cmd.start_x = sx;
        q_cmd.start_y = sy;
        q_cmd.mag_x   = ax;
        q_cmd.mag_y   = ay;
        q_cmd.neg_x   = dx[COORD_BITS];
        q_cmd.neg_y   = dy[COORD_BITS];
        q_cmd.steps   = (ax > ay) ? ax : ay;
    end

    assign s_tready = q_ready;
    assign q_push   = s_tvalid & q_ready;

endmodule

>>> design/dda_queue.sv
// ----------------------------------------------------------------------------
// dda_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dda_queue #(
    parameter int DEPTH = dda_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  dda_pkg::cmd_t push_cmd,
    output logic          push_ready,
    input  logic          pop,
    output logic          pop_valid,
    output dda_pkg::cmd_t pop_cmd
);
    import dda_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    `ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH), "queue overflow")
    `ASSERT_IMPL(a_pop_nonempty, aclk, aresetn, pop, count_reg != '0, "pop from empty queue")
    `ASSERT_IMPL(a_push_room, aclk, aresetn, push, push_ready, "push into full queue")

endmodule

>>> design/dda_back.sv
// ----------------------------------------------------------------------------
// dda_back
// divides the deltas, steps the accumulators and drives the result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dda_back #(
    parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  dda_pkg::cmd_t                 q_cmd,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dda_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import dda_pkg::*;

    localparam int ACC_W  = COORD_BITS + FRAC_BITS + 1;
    localparam int QUO_W  = FRAC_BITS + 1;
    localparam int STEP_W = FRAC_BITS + 2;
    localparam int REM_W  = COORD_BITS + 1;
    localparam int CNT_W  = $clog2(QUO_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ACTIVE
    } state_t;

    state_t                   state_reg;
    logic signed [ACC_W-1:0]  acc_x_reg, acc_y_reg;
    logic        [QUO_W-1:0]  quo_x_reg, quo_y_reg;
    logic        [REM_W-1:0]  rem_x_reg, rem_y_reg;
    logic                     neg_x_reg, neg_y_reg;
    mag_t                     div_reg;
    mag_t                     left_reg;
    logic        [CNT_W-1:0]  cnt_reg;
    logic                     out_valid_reg;
    coord_t                   out_x_reg, out_y_reg;
    logic                     out_last_reg;

    logic                     out_free, is_start;
    logic                     ge_x, ge_y;
    logic        [REM_W-1:0]  sub_x, sub_y;
    logic        [REM_W-1:0]  rem_x_next, rem_y_next;
    logic signed [STEP_W-1:0] step_x, step_y;
    logic signed [ACC_W-1:0]  acc_x_next, acc_y_next;
    logic signed [ACC_W-1:0]  start_x_acc, start_y_acc;

    assign out_free = !out_valid_reg || m_tready;
    assign is_start = q_cmd.op == OP_START;
    assign q_pop    = q_valid && (state_reg != ST_DIVIDE)
                      && (out_free || (!is_start && state_reg == ST_IDLE));

    // restoring division, one quotient bit per cycle for both axes
    assign ge_x  = rem_x_reg >= {1'b0, div_reg};
    assign ge_y  = rem_y_reg >= {1'b0, div_reg};
    assign sub_x = ge_x ? rem_x_reg - {1'b0, div_reg} : rem_x_reg;
    assign sub_y = ge_y ? rem_y_reg - {1'b0, div_reg} : rem_y_reg;
    assign rem_x_next = {sub_x[COORD_BITS-1:0], 1'b0};
    assign rem_y_next = {sub_y[COORD_BITS-1:0], 1'b0};

    // signed increments, accumulators carry a +0.5 bias so rounding is a select
    assign step_x = neg_x_reg ? -STEP_W'(quo_x_reg) : STEP_W'(quo_x_reg);
    assign step_y = neg_y_reg ? -STEP_W'(quo_y_reg) : STEP_W'(quo_y_reg);
    assign acc_x_next = acc_x_reg + {{(ACC_W-STEP_W){step_x[STEP_W-1]}}, step_x};
    assign acc_y_next = acc_y_reg + {{(ACC_W-STEP_W){step_y[STEP_W-1]}}, step_y};

    assign start_x_acc = {q_cmd.start_x[COORD_BITS-1], q_cmd.start_x, 1'b1,
                          {(FRAC_BITS-1){1'b0}}};
    assign start_y_acc = {q_cmd.start_y[COORD_BITS-1], q_cmd.start_y, 1'b1,
                          {(FRAC_BITS-1){1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE, ST_ACTIVE: begin
                    if (q_pop && is_start) begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= q_cmd.start_x;
                        out_y_reg     <= q_cmd.start_y;
                        out_last_reg  <= q_cmd.steps == '0;
                        acc_x_reg     <= start_x_acc;
                        acc_y_reg     <= start_y_acc;
                        rem_x_reg     <= {1'b0, q_cmd.mag_x};
                        rem_y_reg     <= {1'b0, q_cmd.mag_y};
                        neg_x_reg     <= q_cmd.neg_x;
                        neg_y_reg     <= q_cmd.neg_y;
                        div_reg       <= q_cmd.steps;
                        left_reg      <= q_cmd.steps;
                        cnt_reg       <= CNT_W'(QUO_W - 1);
                        state_reg     <= (q_cmd.steps == '0) ? ST_IDLE : ST_DIVIDE;
                    end else if (q_pop && state_reg == ST_ACTIVE) begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= acc_x_next[FRAC_BITS +: COORD_BITS];
                        out_y_reg     <= acc_y_next[FRAC_BITS +: COORD_BITS];
                        out_last_reg  <= left_reg == mag_t'(1);
                        acc_x_reg     <= acc_x_next;
                        acc_y_reg     <= acc_y_next;
                        left_reg      <= left_reg - 1'b1;
                        if (left_reg == mag_t'(1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_DIVIDE: begin
                    rem_x_reg <= rem_x_next;
                    rem_y_reg <= rem_y_next;
                    quo_x_reg <= {quo_x_reg[QUO_W-2:0], ge_x};
                    quo_y_reg <= {quo_y_reg[QUO_W-2:0], ge_y};
                    cnt_reg   <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_ACTIVE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-2*COORD_BITS){1'b0}}, out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;

    `ASSERT_IMPL(a_no_pop_in_divide, aclk, aresetn, state_reg == ST_DIVIDE, !q_pop, "pop during divide")
    `ASSERT_NEXT(a_divide_ends, aclk, aresetn, state_reg == ST_DIVIDE && cnt_reg == '0, state_reg == ST_ACTIVE, "divide did not finish")
    `ASSERT_NEXT(a_start_emits, aclk, aresetn, q_pop && is_start, out_valid_reg, "start point lost")

endmodule

>>> design/dda_line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer_core
// dda line rasterizer with a classifying front, command queue and stepping back
// ----------------------------------------------------------------------------
// A start transfer (tuser = 0) carries both endpoints and produces the start
// point in the cycle after the back end takes it; for a line of nonzero
// length the back end then runs a restoring divider that yields one quotient
// bit per cycle for both axes and takes no further command until it is done.
// Each advance transfer (tuser = 1) needs one add per axis in the back end,
// the sum already biased by one half so the rounded point is a plain bit
// select. The front end takes a transfer in every cycle while the command
// queue has room, so advances queued behind a start wait only for the
// divider and for a free output register. Advances with no line in progress
// are dropped without a result, a zero-length line gives just its start
// point with tlast set, and a start during a line abandons the old one.
// Every result sits in an output register and may stall on m_tready
// without blocking the queue from filling.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_core #(
    parameter int FRAC_BITS   = dda_pkg::FRAC_BITS_DEF,  // 8 to 24
    parameter int QUEUE_DEPTH = dda_pkg::QUEUE_DEPTH_DEF // 2 or more
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dda_pkg::S_TDATA_W-1:0] s_tdata,   // start_x, start_y, end_x, end_y, pad
    input  logic                          s_tuser,   // operation: 0 start, 1 advance
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dda_pkg::M_TDATA_W-1:0] m_tdata,   // point_x, point_y, pad
    output logic                          m_tlast    // last_point
);
    import dda_pkg::*;

    // front to queue
    logic push, push_ready;
    cmd_t push_cmd;

    // queue to back
    logic pop, pop_valid;
    cmd_t pop_cmd;

    // classify each transfer: deltas, magnitudes, signs and step count
    dda_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_ready  (push_ready),
        .q_push   (push),
        .q_cmd    (push_cmd)
    );

    // decouples input acceptance from divider and output stalls
    dda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd)
    );

    // divider, accumulators and output register
    dda_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (pop_valid),
        .q_cmd    (pop_cmd),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
